// ===== hdl/pccf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the palette color crossfade unit.
// Holds widths, the controller state type and the fixed palette ROM.
// No dependencies.
package pccf_pkg;

  localparam int unsigned IDX_W         = 3;
  localparam int unsigned FADE_W        = 16;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned COLOR_W       = 3 * CHAN_W;
  localparam int unsigned PROD_W        = FADE_W + CHAN_W;
  localparam int unsigned NUM_CHAN      = 6;
  localparam int unsigned CHAN_CNT_W    = 3;
  localparam int unsigned BIT_CNT_W     = 3;
  localparam int unsigned STEP_BITS_DEF = 16;

  localparam logic [FADE_W-1:0] FADE_STEPS_RST = 16'd100;
  localparam logic [IDX_W-1:0]  IDX_WHITE      = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  function automatic logic [COLOR_W-1:0] pal_primary(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      3'd0:    c = 24'hFF7F00;
      3'd1:    c = 24'hFFFF00;
      3'd2:    c = 24'hFF7F00;
      3'd3:    c = 24'h7FFF00;
      3'd4:    c = 24'hFFFFFF;
      3'd5:    c = 24'h00FFFF;
      3'd6:    c = 24'h7F00FF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [COLOR_W-1:0] pal_secondary(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      3'd0:    c = 24'hFF007F;
      3'd1:    c = 24'hFF7F00;
      3'd2:    c = 24'hFF0000;
      3'd3:    c = 24'h00FF7F;
      3'd4:    c = 24'hFFFFFF;
      3'd5:    c = 24'h00FF7F;
      3'd6:    c = 24'h007FFF;
      default: c = 24'h040404;
    endcase
    // White in the secondary table is the dim grey entry.
    if (idx == 3'd4) begin
      c = 24'h040404;
    end
    return c;
  endfunction

  // Channel order: primary red, green, blue, then secondary red, green, blue.
  function automatic logic [CHAN_W-1:0] pal_byte(input logic [IDX_W-1:0] idx,
                                                input logic [CHAN_CNT_W-1:0] chan);
    logic [CHAN_W-1:0]  b;
    logic [COLOR_W-1:0] p;
    logic [COLOR_W-1:0] s;
    p = pal_primary(idx);
    s = pal_secondary(idx);
    case (chan)
      3'd0:    b = p[23:16];
      3'd1:    b = p[15:8];
      3'd2:    b = p[7:0];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      default: b = s[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/palette_color_crossfade_unit.sv =====
`timescale 1ns / 1ps
// Top level of the palette color crossfade unit.
// Depends on pccf_pkg for widths, the state type and the palette ROM.

// Each accepted word carries a target palette index and yields one result word.
// A tick that completes a change (step count not below fade_steps) goes from
// idle to the done state, which loads the result register once it is free. A
// tick that interpolates computes six 8-bit channels one after another on one
// shared shift-add multiplier and one restoring divider, each retiring one bit
// per cycle; each channel passes through the load, multiply and divide states.
// A new word is accepted whenever the controller is idle, even while the
// previous result still waits in the output register. fade_steps is written
// through its own valid/ready port, which is always ready.
module palette_color_crossfade_unit
  import pccf_pkg::*;
#(
  parameter int unsigned STEP_BITS = STEP_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [IDX_W-1:0]   target_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FADE_W-1:0]  fade_steps_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COLOR_W-1:0] primary_color_o,
  output logic [COLOR_W-1:0] secondary_color_o,
  output logic               fading_o
);

  localparam int unsigned CMP_W = (STEP_BITS > FADE_W) ? STEP_BITS : FADE_W;

  ctrl_state_e state_q, state_d;

  logic [FADE_W-1:0]      fade_steps_q;
  logic [IDX_W-1:0]       cur_idx_q;
  logic [STEP_BITS-1:0]   step_cnt_q;
  logic                   out_valid_q;
  logic [COLOR_W-1:0]     primary_q, secondary_q;
  logic                   fading_q;

  logic [IDX_W-1:0]       src_idx_q, tgt_idx_q;
  logic [FADE_W-1:0]      step_op_q;
  logic                   fade_tick_q;
  logic [CHAN_CNT_W-1:0]  chan_q;
  logic [BIT_CNT_W-1:0]   bit_cnt_q;
  logic [CHAN_W-1:0]      base_q, mag_q, dvd_q, quo_q;
  logic                   neg_q;
  logic [PROD_W-1:0]      acc_q;
  logic [FADE_W-1:0]      rem_q;
  logic [2*COLOR_W-1:0]   res_q;

  logic                   accept, out_take, out_load, is_fade, last_bit, last_chan;
  logic [PROD_W-1:0]      acc_d;
  logic [FADE_W:0]        trial;
  logic                   ge;
  logic [FADE_W-1:0]      rem_d;
  logic [CHAN_W-1:0]      quo_d, chan_res;
  logic [CHAN_W-1:0]      byte_a, byte_b;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;
  assign is_fade   = CMP_W'(step_cnt_q) < CMP_W'(fade_steps_q);
  assign last_bit  = bit_cnt_q == BIT_CNT_W'(CHAN_W - 1);
  assign last_chan = chan_q == CHAN_CNT_W'(NUM_CHAN - 1);

  assign byte_a = pal_byte(src_idx_q, chan_q);
  assign byte_b = pal_byte(tgt_idx_q, chan_q);

  // Shift-add multiply, most significant multiplier bit first.
  assign acc_d = {acc_q[PROD_W-2:0], 1'b0} + (mag_q[CHAN_W-1] ? PROD_W'(step_op_q) : '0);

  // Restoring division step; the partial remainder always stays below fade_steps.
  assign trial = {rem_q, dvd_q[CHAN_W-1]};
  assign ge    = trial >= {1'b0, fade_steps_q};
  assign rem_d = ge ? FADE_W'(trial - {1'b0, fade_steps_q}) : trial[FADE_W-1:0];
  assign quo_d = {quo_q[CHAN_W-2:0], ge};

  // A negative difference rounds toward minus infinity: subtract one more on a remainder.
  assign chan_res = neg_q ? (base_q - quo_d - CHAN_W'(rem_d != '0)) : (base_q + quo_d);

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          state_d = is_fade ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (last_bit) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_bit) begin
          state_d = last_chan ? ST_DONE : ST_LOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fade_steps_q <= FADE_STEPS_RST;
      cur_idx_q    <= IDX_WHITE;
      step_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        fade_steps_q <= fade_steps_i;
      end
      if (accept) begin
        if (is_fade) begin
          step_cnt_q <= step_cnt_q + STEP_BITS'(1);
        end else begin
          step_cnt_q <= '0;
          cur_idx_q  <= target_index_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          src_idx_q   <= cur_idx_q;
          tgt_idx_q   <= target_index_i;
          step_op_q   <= FADE_W'(step_cnt_q);
          fade_tick_q <= is_fade;
          chan_q      <= '0;
          res_q       <= {pal_primary(target_index_i), pal_secondary(target_index_i)};
        end
      end
      ST_LOAD: begin
        base_q    <= byte_a;
        neg_q     <= byte_b < byte_a;
        mag_q     <= (byte_b < byte_a) ? (byte_a - byte_b) : (byte_b - byte_a);
        acc_q     <= '0;
        bit_cnt_q <= '0;
      end
      ST_MUL: begin
        acc_q     <= acc_d;
        mag_q     <= {mag_q[CHAN_W-2:0], 1'b0};
        bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
        if (last_bit) begin
          // The quotient fits in one byte, so the upper product bits seed the remainder.
          rem_q <= acc_d[PROD_W-1:CHAN_W];
          dvd_q <= acc_d[CHAN_W-1:0];
          quo_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q     <= rem_d;
        quo_q     <= quo_d;
        dvd_q     <= {dvd_q[CHAN_W-2:0], 1'b0};
        bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
        if (last_bit) begin
          res_q  <= {res_q[2*COLOR_W-CHAN_W-1:0], chan_res};
          chan_q <= chan_q + CHAN_CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          primary_q   <= res_q[2*COLOR_W-1:COLOR_W];
          secondary_q <= res_q[COLOR_W-1:0];
          fading_q    <= fade_tick_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign primary_color_o   = primary_q;
  assign secondary_color_o = secondary_q;
  assign fading_o          = fading_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for palette_color_crossfade_unit: directed and random ticks, each result word
// scored against an untimed model of the fade. Depends on pccf_pkg and the top level.
module testbench;
  import pccf_pkg::*;

  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TAIL_CYCLES  = 120;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned CALM_LO      = 450;
  localparam int unsigned CALM_HI      = 600;
  localparam int unsigned NUM_PHASES   = 14;
  localparam int unsigned HOLD_PHASE   = 2;
  localparam logic [FADE_W-1:0] FADE_MAX = '1;

  typedef struct packed {
    logic [COLOR_W-1:0] primary;
    logic [COLOR_W-1:0] secondary;
    logic               fading;
  } color_word_t;

  class crossfade_scoreboard;
    logic [FADE_W-1:0]        fade_len;
    logic [IDX_W-1:0]         cur_idx;
    logic [STEP_BITS_DEF-1:0] step_cnt;
    logic                     last_fading;
    color_word_t              pending_q[$];
    int unsigned              noted;
    int unsigned              checked;
    int unsigned              errors;

    function new();
      fade_len    = FADE_STEPS_RST;
      cur_idx     = IDX_WHITE;
      step_cnt    = '0;
      last_fading = 1'b0;
      noted       = 0;
      checked     = 0;
      errors      = 0;
    endfunction

    function logic [COLOR_W-1:0] primary_of(logic [IDX_W-1:0] idx);
      case (idx)
        3'd0:    return 24'hFF7F00;
        3'd1:    return 24'hFFFF00;
        3'd2:    return 24'hFF7F00;
        3'd3:    return 24'h7FFF00;
        3'd5:    return 24'h00FFFF;
        3'd6:    return 24'h7F00FF;
        default: return 24'hFFFFFF;
      endcase
    endfunction

    function logic [COLOR_W-1:0] secondary_of(logic [IDX_W-1:0] idx);
      case (idx)
        3'd0:    return 24'hFF007F;
        3'd1:    return 24'hFF7F00;
        3'd2:    return 24'hFF0000;
        3'd3:    return 24'h00FF7F;
        3'd5:    return 24'h00FF7F;
        3'd6:    return 24'h007FFF;
        default: return 24'h040404;
      endcase
    endfunction

    // Division in SystemVerilog truncates, so negative quotients are pulled down to the floor.
    function logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                              int unsigned step, int unsigned len);
      longint num;
      longint q;
      longint v;
      num = longint'(step) * (longint'(b) - longint'(a));
      q   = num / longint'(len);
      if ((num % longint'(len)) != 0 && num < 0) begin
        q = q - 1;
      end
      v = longint'(a) + q;
      if (v < 0) begin
        v = 0;
      end
      if (v > 255) begin
        v = 255;
      end
      return v[CHAN_W-1:0];
    endfunction

    function logic [COLOR_W-1:0] blend_color(logic [COLOR_W-1:0] c0, logic [COLOR_W-1:0] c1,
                                             int unsigned step, int unsigned len);
      logic [COLOR_W-1:0] c;
      for (int k = 0; k < 3; k++) begin
        c[k*CHAN_W +: CHAN_W] = blend_channel(c0[k*CHAN_W +: CHAN_W], c1[k*CHAN_W +: CHAN_W],
                                              step, len);
      end
      return c;
    endfunction

    function void set_fade(logic [FADE_W-1:0] v);
      fade_len = v;
    endfunction

    function void note_word(logic [IDX_W-1:0] tgt);
      color_word_t w;
      if (step_cnt < fade_len) begin
        w.primary   = blend_color(primary_of(cur_idx), primary_of(tgt), step_cnt, fade_len);
        w.secondary = blend_color(secondary_of(cur_idx), secondary_of(tgt), step_cnt, fade_len);
        w.fading    = 1'b1;
        step_cnt    = step_cnt + 1'b1;
      end else begin
        cur_idx     = tgt;
        w.primary   = primary_of(tgt);
        w.secondary = secondary_of(tgt);
        w.fading    = 1'b0;
        step_cnt    = '0;
      end
      last_fading = w.fading;
      pending_q.push_back(w);
      noted++;
    endfunction

    function void check_word(logic [COLOR_W-1:0] p, logic [COLOR_W-1:0] s, logic f);
      color_word_t w;
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: result word with none expected: primary %06h secondary %06h fading %0b",
                 $time, p, s, f);
        errors++;
        return;
      end
      w = pending_q.pop_front();
      if (p !== w.primary) begin
        $display("%0t: primary_color expected %06h, got %06h", $time, w.primary, p);
        errors++;
      end
      if (s !== w.secondary) begin
        $display("%0t: secondary_color expected %06h, got %06h", $time, w.secondary, s);
        errors++;
      end
      if (f !== w.fading) begin
        $display("%0t: fading expected %0b, got %0b", $time, w.fading, f);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic [IDX_W-1:0]   target_index_i = '0;
  logic               cfg_valid_i    = 1'b0;
  logic [FADE_W-1:0]  fade_steps_i   = '0;
  logic               out_stall_i    = 1'b0;
  logic               in_stall_o;
  logic               cfg_ready_o;
  logic               out_valid_o;
  logic [COLOR_W-1:0] primary_color_o;
  logic [COLOR_W-1:0] secondary_color_o;
  logic               fading_o;

  logic                hold_req  = 1'b0;
  int unsigned         cycle_cnt = 0;
  crossfade_scoreboard sb        = new();

  palette_color_crossfade_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_index_i   (target_index_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .fade_steps_i     (fade_steps_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .primary_color_o  (primary_color_o),
    .secondary_color_o(secondary_color_o),
    .fading_o         (fading_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_word(primary_color_o, secondary_color_o, fading_o);
    end
  end

  // Receiver: random stalls, a calm window, and one long hold that backs up the input.
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (sb.checked >= CALM_LO && sb.checked < CALM_HI) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_word(input logic [IDX_W-1:0] idx);
    while (!(sb.noted >= CALM_LO && sb.noted < CALM_HI) && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    target_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(idx);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_fade(input logic [FADE_W-1:0] v);
    drain();
    cfg_valid_i  <= 1'b1;
    fade_steps_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_fade(v);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned      ph;
    int unsigned      n;
    int unsigned      sent;
    int unsigned      len;
    logic [IDX_W-1:0] tgt;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fade at the reset length, starting from white.
    send_word(3'd7);
    send_word(3'd0);
    // Zero fade length: every tick adopts its target, index seven included.
    write_fade('0);
    for (int k = 0; k < 8; k++) begin
      send_word(k[IDX_W-1:0]);
    end
    write_fade(16'd1);
    send_word(3'd3);
    send_word(3'd3);
    send_word(3'd6);
    send_word(3'd6);
    // Target changes while a fade is still running.
    write_fade(16'd4);
    send_word(3'd0);
    send_word(3'd5);
    send_word(3'd1);
    send_word(3'd2);
    send_word(3'd2);
    write_fade(FADE_MAX);
    send_word(3'd5);
    send_word(3'd0);
    // Shrinking the length to the running count completes on the next tick.
    write_fade(16'd2);
    send_word(3'd1);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 7)
        0:       len = 0;
        1:       len = 1;
        2:       len = $urandom_range(2, 24);
        3:       len = FADE_MAX;
        4:       len = $urandom_range(25, FADE_MAX);
        5:       len = FADE_STEPS_RST;
        default: len = $urandom_range(2, 12);
      endcase
      n = (len > 200) ? 20 : 95;
      write_fade(len[FADE_W-1:0]);
      if (ph == HOLD_PHASE) begin
        hold_req <= 1'b1;
      end
      sent = 0;
      while (sent < n) begin
        tgt = $urandom_range(7);
        if ($urandom_range(99) < 80) begin
          // Hold one target until its fade completes.
          do begin
            send_word(tgt);
            sent++;
          end while (sb.last_fading && sent < n);
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_word(tgt);
            tgt = $urandom_range(7);
            sent++;
          end
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
